>>> src/ste_pkg.sv
// Shared types and constants of the stereo treble exciter.
`timescale 1ns / 1ps

package ste_pkg;

  // Sample, coefficient and internal word formats
  localparam int SAMPLE_BITS = 24;
  localparam int COEFF_BITS  = 26;
  localparam int SFRAC       = SAMPLE_BITS - 1;
  localparam int CFRAC       = COEFF_BITS - 4;
  localparam int GAIN_BITS   = 24;
  localparam int GAIN_FRAC   = 19;
  localparam int SHAPE_BITS  = 16;
  localparam int WORD_BITS   = 32;
  localparam int OPND_BITS   = WORD_BITS + 1;
  localparam int PROD_BITS   = 2 * OPND_BITS;
  localparam int ACC_BITS    = 48;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_B0    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_A1    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_A2    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_B0   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_A1   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_A2   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WET_GAIN    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SHAPE_COEFF = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } result_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC
  } state_t;

  // One multiply per step: low-pass taps, shaper, high-pass taps, wet mix
  typedef enum logic [3:0] {
    LP_X0,
    LP_X1,
    LP_X2,
    LP_Y1,
    LP_Y2,
    SH_MAG,
    SH_MUL,
    HP_X0,
    HP_X1,
    HP_X2,
    HP_Y1,
    HP_Y2,
    MIX_OUT
  } step_t;

  typedef struct packed {
    logic  mul_en;
    logic  acc_en;
    step_t step;
  } mac_ctl_t;

endpackage

>>> src/ste_mac.sv
// Shared multiplier with accumulator, shaper gain and saturation logic.
`timescale 1ns / 1ps

module ste_mac
  import ste_pkg::*;
(
  input  logic                          clk,
  input  mac_ctl_t                      ctl,
  input  logic signed [OPND_BITS-1:0]   op_a,
  input  logic signed [OPND_BITS-1:0]   op_b,
  input  logic signed [SAMPLE_BITS-1:0] dry,
  output logic signed [WORD_BITS-1:0]   wv,
  output logic signed [OPND_BITS-1:0]   kval,
  output logic signed [WORD_BITS-1:0]   biq_y,
  output logic signed [SAMPLE_BITS-1:0] mix
);

  localparam logic signed [OPND_BITS-1:0] K_ONE = OPND_BITS'(64'd1 << SFRAC);

  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [PROD_BITS-1:0] sh_c;
  logic signed [PROD_BITS-1:0] sh_s;
  logic signed [PROD_BITS-1:0] sh_m;
  logic signed [PROD_BITS-1:0] sh_g;
  logic signed [ACC_BITS-1:0]  p_c;
  logic signed [ACC_BITS-1:0]  p_s;
  logic signed [ACC_BITS-1:0]  p_g;
  logic signed [ACC_BITS-1:0]  biq_sum;
  logic signed [ACC_BITS-1:0]  mix_sum;

  // Clamp a wide value to a signed word
  function automatic logic signed [WORD_BITS-1:0] sat_word(
    input logic signed [ACC_BITS-1:0] v
  );
    logic [ACC_BITS-WORD_BITS:0] top;
    top = v[ACC_BITS-1:WORD_BITS-1];
    if ((&top) || !(|top)) begin
      return v[WORD_BITS-1:0];
    end else if (v[ACC_BITS-1]) begin
      return {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_BITS-1){1'b1}}};
    end
  endfunction

  // Clamp a wide value to a signed sample
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [ACC_BITS-1:0] v
  );
    logic [ACC_BITS-SAMPLE_BITS:0] top;
    top = v[ACC_BITS-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[ACC_BITS-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  // Floor the registered product to each fixed-point format
  assign sh_c = prod >>> CFRAC;
  assign sh_s = prod >>> SFRAC;
  assign sh_m = prod >>> SHAPE_BITS;
  assign sh_g = prod >>> GAIN_FRAC;
  assign p_c  = sh_c[ACC_BITS-1:0];
  assign p_s  = sh_s[ACC_BITS-1:0];
  assign p_g  = sh_g[ACC_BITS-1:0];

  // Last feedback tap closes the biquad sum
  assign biq_sum = acc - p_c;
  assign biq_y   = sat_word(biq_sum);

  // Dry sample plus scaled wet signal
  assign mix_sum = ACC_BITS'(dry) + p_g;
  assign mix     = sat_sample(mix_sum);

  // Multiply
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= PROD_BITS'(op_a) * PROD_BITS'(op_b);
    end
  end

  // Accumulate or capture the step result
  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      unique case (ctl.step)
        LP_X0, HP_X0: acc <= p_c;
        LP_X1:        acc <= acc + (p_c <<< 1);
        HP_X1:        acc <= acc - (p_c <<< 1);
        LP_X2, HP_X2: acc <= acc + p_c;
        LP_Y1, HP_Y1: acc <= acc - p_c;
        LP_Y2, HP_Y2: wv <= biq_y;
        SH_MAG:       kval <= K_ONE - sh_m[OPND_BITS-1:0];
        SH_MUL:       wv <= sat_word(p_s);
        MIX_OUT:      acc <= acc;
        default:      acc <= acc;
      endcase
    end
  end

endmodule

>>> src/stereo_treble_exciter_unit.sv
// Top level of the stereo treble exciter: sequencer, registers and history.
`timescale 1ns / 1ps

// Stereo treble exciter. Each accepted sample pair runs both channels through
// a low-pass biquad, the waveshaper x*(1-|c*x|), a high-pass biquad and a wet
// mix onto the dry sample, all on one shared 33x33 multiplier. A channel takes
// 13 multiplies and each multiply has a multiply state, then an accumulate
// state; after the right channel the sequencer goes back to idle to accept the
// next request. The sample channel stalls while a pair is being worked on. The
// finished pair sits in an output register; if the previous result is still
// waiting there, the last step holds until it is taken. Coefficient registers
// are written through the configuration port, which is always ready; write
// them only while the block is idle.
module stereo_treble_exciter_unit
  import ste_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  sample_t                  sample,
  output logic                     result_valid,
  input  logic                     result_stall,
  output result_t                  result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // Configuration registers
  logic signed [COEFF_BITS-1:0] first_b0;
  logic signed [COEFF_BITS-1:0] first_a1;
  logic signed [COEFF_BITS-1:0] first_a2;
  logic signed [COEFF_BITS-1:0] second_b0;
  logic signed [COEFF_BITS-1:0] second_a1;
  logic signed [COEFF_BITS-1:0] second_a2;
  logic [GAIN_BITS-1:0]         wet_gain;
  logic [SHAPE_BITS-1:0]        shape_coeff;

  // Filter history, per channel one and two samples back
  logic signed [SAMPLE_BITS-1:0] fxh [2][2];
  logic signed [WORD_BITS-1:0]   fyh [2][2];
  logic signed [WORD_BITS-1:0]   sxh [2][2];
  logic signed [WORD_BITS-1:0]   syh [2][2];

  // Sequencer
  state_t state;
  state_t state_next;
  step_t  step;
  step_t  step_next;
  logic   ch;
  logic   ch_next;

  sample_t                       sample_reg;
  logic signed [SAMPLE_BITS-1:0] left_res;
  logic                          accept;
  logic                          load_left;
  logic                          load_out;
  logic                          can_load;
  mac_ctl_t                      ctl;

  logic signed [SAMPLE_BITS-1:0] dry;
  logic signed [OPND_BITS-1:0]   op_a;
  logic signed [OPND_BITS-1:0]   op_b;
  logic signed [OPND_BITS-1:0]   wv_ext;
  logic signed [OPND_BITS-1:0]   wv_mag;
  logic signed [WORD_BITS-1:0]   wv;
  logic signed [OPND_BITS-1:0]   kval;
  logic signed [WORD_BITS-1:0]   biq_y;
  logic signed [SAMPLE_BITS-1:0] mix;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign can_load     = !result_valid || !result_stall;
  assign dry          = ch ? sample_reg.right_in : sample_reg.left_in;

  // Write configuration registers, mask extra data bits
  always_ff @(posedge clk) begin
    if (rst) begin
      first_b0    <= '0;
      first_a1    <= '0;
      first_a2    <= '0;
      second_b0   <= '0;
      second_a1   <= '0;
      second_a2   <= '0;
      wet_gain    <= '0;
      shape_coeff <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIRST_B0:    first_b0    <= cfg_data[COEFF_BITS-1:0];
        CFG_FIRST_A1:    first_a1    <= cfg_data[COEFF_BITS-1:0];
        CFG_FIRST_A2:    first_a2    <= cfg_data[COEFF_BITS-1:0];
        CFG_SECOND_B0:   second_b0   <= cfg_data[COEFF_BITS-1:0];
        CFG_SECOND_A1:   second_a1   <= cfg_data[COEFF_BITS-1:0];
        CFG_SECOND_A2:   second_a2   <= cfg_data[COEFF_BITS-1:0];
        CFG_WET_GAIN:    wet_gain    <= cfg_data[GAIN_BITS-1:0];
        CFG_SHAPE_COEFF: shape_coeff <= cfg_data[SHAPE_BITS-1:0];
        default:         wet_gain    <= wet_gain;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= LP_X0;
      ch    <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      ch    <= ch_next;
    end
  end

  // Next state and MAC control
  always_comb begin
    state_next  = state;
    step_next   = step;
    ch_next     = ch;
    load_left   = 1'b0;
    load_out    = 1'b0;
    ctl.mul_en  = 1'b0;
    ctl.acc_en  = 1'b0;
    ctl.step    = step;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_MUL;
          step_next  = LP_X0;
          ch_next    = 1'b0;
        end
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        ctl.acc_en = 1'b1;
        if (step != MIX_OUT) begin
          step_next  = step_t'(step + 4'd1);
          state_next = ST_MUL;
        end else if (!ch) begin
          load_left  = 1'b1;
          ch_next    = 1'b1;
          step_next  = LP_X0;
          state_next = ST_MUL;
        end else if (can_load) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Select operands for the shared multiplier
  assign wv_ext = OPND_BITS'(wv);
  assign wv_mag = wv[WORD_BITS-1] ? -wv_ext : wv_ext;

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step)
      LP_X0: begin
        op_a = OPND_BITS'(dry);
        op_b = OPND_BITS'(first_b0);
      end
      LP_X1: begin
        op_a = OPND_BITS'(fxh[ch][0]);
        op_b = OPND_BITS'(first_b0);
      end
      LP_X2: begin
        op_a = OPND_BITS'(fxh[ch][1]);
        op_b = OPND_BITS'(first_b0);
      end
      LP_Y1: begin
        op_a = OPND_BITS'(fyh[ch][0]);
        op_b = OPND_BITS'(first_a1);
      end
      LP_Y2: begin
        op_a = OPND_BITS'(fyh[ch][1]);
        op_b = OPND_BITS'(first_a2);
      end
      SH_MAG: begin
        op_a = wv_mag;
        op_b = OPND_BITS'(shape_coeff);
      end
      SH_MUL: begin
        op_a = wv_ext;
        op_b = kval;
      end
      HP_X0: begin
        op_a = wv_ext;
        op_b = OPND_BITS'(second_b0);
      end
      HP_X1: begin
        op_a = OPND_BITS'(sxh[ch][0]);
        op_b = OPND_BITS'(second_b0);
      end
      HP_X2: begin
        op_a = OPND_BITS'(sxh[ch][1]);
        op_b = OPND_BITS'(second_b0);
      end
      HP_Y1: begin
        op_a = OPND_BITS'(syh[ch][0]);
        op_b = OPND_BITS'(second_a1);
      end
      HP_Y2: begin
        op_a = OPND_BITS'(syh[ch][1]);
        op_b = OPND_BITS'(second_a2);
      end
      MIX_OUT: begin
        op_a = wv_ext;
        op_b = OPND_BITS'(wet_gain);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  ste_mac u_mac (
    .clk   (clk),
    .ctl   (ctl),
    .op_a  (op_a),
    .op_b  (op_b),
    .dry   (dry),
    .wv    (wv),
    .kval  (kval),
    .biq_y (biq_y),
    .mix   (mix)
  );

  // Advance filter history when a biquad closes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        for (int t = 0; t < 2; t++) begin
          fxh[c][t] <= '0;
          fyh[c][t] <= '0;
          sxh[c][t] <= '0;
          syh[c][t] <= '0;
        end
      end
    end else if (ctl.acc_en && step == LP_Y2) begin
      fxh[ch][1] <= fxh[ch][0];
      fxh[ch][0] <= dry;
      fyh[ch][1] <= fyh[ch][0];
      fyh[ch][0] <= biq_y;
    end else if (ctl.acc_en && step == HP_Y2) begin
      sxh[ch][1] <= sxh[ch][0];
      sxh[ch][0] <= wv;
      syh[ch][1] <= syh[ch][0];
      syh[ch][0] <= biq_y;
    end
  end

  // Hold the request and the left result, and load the output pair
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_reg <= sample;
    end
    if (load_left) begin
      left_res <= mix;
    end
    if (load_out) begin
      result.left_out  <= left_res;
      result.right_out <= mix;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // A result appears only after the right channel mix step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_ACC && step == MIX_OUT && ch))
    else $error("result raised outside the final mix step");

  // An accepted request starts the left channel at the first tap
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_MUL && step == LP_X0 && !ch))
    else $error("request did not start the left channel");

  // Switch channels only after the left mix step
  a_channel_switch: assert property (@(posedge clk) disable iff (rst)
    $rose(ch) |-> $past(step == MIX_OUT && state == ST_ACC))
    else $error("channel switched before the mix step");

  // Never overwrite a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !load_out)
    else $error("pending result overwritten");

endmodule

>>> bench/stereo_treble_exciter_unit_tb.sv
// Testbench for the stereo treble exciter: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module stereo_treble_exciter_unit_tb;
  import ste_pkg::*;

  localparam int NUM_REGS       = 8;
  localparam int MAX_WAIT       = 10;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 250;
  localparam int MAX_REPORTS    = 40;
  localparam int COEF_MAX       = (1 << (COEFF_BITS - 1)) - 1;
  localparam int COEF_MIN       = -(1 << (COEFF_BITS - 1));
  localparam int GAIN_MAX       = (1 << GAIN_BITS) - 1;
  localparam int SHAPE_MAX      = (1 << SHAPE_BITS) - 1;

  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {SFRAC{1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {SFRAC{1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] S_ONE = SAMPLE_BITS'(1);
  localparam logic [SAMPLE_BITS-1:0] S_NEG = '1;
  localparam logic [SAMPLE_BITS-1:0] S_ZERO = '0;

  typedef logic [NUM_REGS-1:0][CFG_DATA_BITS-1:0] settings_t;

  logic    clk;
  logic    rst;
  logic    sample_valid;
  logic    sample_stall;
  sample_t sample;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  stereo_treble_exciter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Predictor copy of the registers and of the per-channel filter history
  longint  coef [NUM_REGS];
  longint  lp_in [2][2];
  longint  lp_out [2][2];
  longint  hp_in [2][2];
  longint  hp_out [2][2];
  result_t pending_outputs [$];

  int   errors;
  bit   no_idle;
  logic hold_pulse;
  int   rx_wait;
  bit   rx_armed;
  int   stuck_cycles;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  // Predictor -----------------------------------------------------------------

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint biquad_out(input longint x0, input longint x1, input longint x2,
                                        input longint y1, input longint y2, input longint b0,
                                        input longint dir, input longint a1, input longint a2);
    longint acc;
    acc = ((b0 * x0) >>> CFRAC) + dir * 2 * ((b0 * x1) >>> CFRAC) + ((b0 * x2) >>> CFRAC)
        - ((a1 * y1) >>> CFRAC) - ((a2 * y2) >>> CFRAC);
    return clamp(acc, WORD_BITS);
  endfunction

  function automatic longint soft_clip(input longint x);
    longint mag;
    longint knee;
    mag  = (x < 0) ? -x : x;
    knee = (longint'(1) << SFRAC) - ((coef[CFG_SHAPE_COEFF] * mag) >>> SHAPE_BITS);
    return clamp((x * knee) >>> SFRAC, WORD_BITS);
  endfunction

  function automatic longint run_channel(input longint dry, input int ch);
    longint lp;
    longint shaped;
    longint hp;
    lp = biquad_out(dry, lp_in[ch][0], lp_in[ch][1], lp_out[ch][0], lp_out[ch][1],
                    coef[CFG_FIRST_B0], 1, coef[CFG_FIRST_A1], coef[CFG_FIRST_A2]);
    lp_in[ch][1]  = lp_in[ch][0];
    lp_in[ch][0]  = dry;
    lp_out[ch][1] = lp_out[ch][0];
    lp_out[ch][0] = lp;
    shaped = soft_clip(lp);
    hp = biquad_out(shaped, hp_in[ch][0], hp_in[ch][1], hp_out[ch][0], hp_out[ch][1],
                    coef[CFG_SECOND_B0], -1, coef[CFG_SECOND_A1], coef[CFG_SECOND_A2]);
    hp_in[ch][1]  = hp_in[ch][0];
    hp_in[ch][0]  = shaped;
    hp_out[ch][1] = hp_out[ch][0];
    hp_out[ch][0] = hp;
    return clamp(dry + ((coef[CFG_WET_GAIN] * hp) >>> GAIN_FRAC), SAMPLE_BITS);
  endfunction

  function automatic result_t excite_pair(input sample_t s);
    result_t r;
    longint  lo;
    longint  ro;
    lo = run_channel(longint'($signed(s.left_in)), 0);
    ro = run_channel(longint'($signed(s.right_in)), 1);
    r.left_out  = lo[SAMPLE_BITS-1:0];
    r.right_out = ro[SAMPLE_BITS-1:0];
    return r;
  endfunction

  // Keep only the bits each register holds
  function automatic void store_setting(input logic [CFG_IDX_BITS-1:0] idx,
                                        input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_WET_GAIN:    coef[idx] = longint'(data[GAIN_BITS-1:0]);
      CFG_SHAPE_COEFF: coef[idx] = longint'(data[SHAPE_BITS-1:0]);
      default:         coef[idx] = longint'($signed(data[COEFF_BITS-1:0]));
    endcase
  endfunction

  // Stimulus helpers ----------------------------------------------------------

  function automatic sample_t make_pair(input logic [SAMPLE_BITS-1:0] l,
                                        input logic [SAMPLE_BITS-1:0] r);
    sample_t s;
    s.left_in  = l;
    s.right_in = r;
    return s;
  endfunction

  // Mix of full-range, extreme and quiet samples
  function automatic logic [SAMPLE_BITS-1:0] rand_field();
    logic signed [SAMPLE_BITS-1:0] v;
    v = SAMPLE_BITS'($urandom);
    case ($urandom_range(0, 5))
      0: v = S_MAX;
      1: v = S_MIN;
      2: v = v >>> $urandom_range(0, SFRAC - 1);
      default: ;
    endcase
    return v;
  endfunction

  function automatic int jitter();
    return int'($urandom_range(0, 8192)) - 4096;
  endfunction

  function automatic int pick_extreme(input int lo, input int hi);
    case ($urandom_range(0, 2))
      0: return lo;
      1: return hi;
      default: return 0;
    endcase
  endfunction

  // Stable filter pairs most of the time, otherwise raw words or extremes
  function automatic settings_t random_settings();
    settings_t w;
    int        style;
    style = $urandom_range(0, 9);
    if (style < 6) begin
      if ($urandom_range(0, 1) == 1) begin
        w[CFG_FIRST_B0] = CFG_DATA_BITS'(409490 + jitter());
        w[CFG_FIRST_A1] = CFG_DATA_BITS'(-3954460 + jitter());
        w[CFG_FIRST_A2] = CFG_DATA_BITS'(1398101 + jitter());
      end else begin
        w[CFG_FIRST_B0] = CFG_DATA_BITS'(1228495 + jitter());
        w[CFG_FIRST_A1] = CFG_DATA_BITS'(jitter());
        w[CFG_FIRST_A2] = CFG_DATA_BITS'(719750 + jitter());
      end
      if ($urandom_range(0, 1) == 1) begin
        w[CFG_SECOND_B0] = CFG_DATA_BITS'(2386720 + jitter());
        w[CFG_SECOND_A1] = CFG_DATA_BITS'(-3954460 + jitter());
        w[CFG_SECOND_A2] = CFG_DATA_BITS'(1398101 + jitter());
      end else begin
        w[CFG_SECOND_B0] = CFG_DATA_BITS'(1228495 + jitter());
        w[CFG_SECOND_A1] = CFG_DATA_BITS'(jitter());
        w[CFG_SECOND_A2] = CFG_DATA_BITS'(719750 + jitter());
      end
      w[CFG_WET_GAIN]    = $urandom_range(0, 1 << 22);
      w[CFG_SHAPE_COEFF] = $urandom_range(0, SHAPE_MAX);
    end else if (style < 8) begin
      for (int i = 0; i < NUM_REGS; i++) w[i] = $urandom;
    end else begin
      w[CFG_FIRST_B0]    = CFG_DATA_BITS'(pick_extreme(COEF_MIN, COEF_MAX));
      w[CFG_FIRST_A1]    = CFG_DATA_BITS'(pick_extreme(COEF_MIN, COEF_MAX));
      w[CFG_FIRST_A2]    = CFG_DATA_BITS'(pick_extreme(COEF_MIN, COEF_MAX));
      w[CFG_SECOND_B0]   = CFG_DATA_BITS'(pick_extreme(COEF_MIN, COEF_MAX));
      w[CFG_SECOND_A1]   = CFG_DATA_BITS'(pick_extreme(COEF_MIN, COEF_MAX));
      w[CFG_SECOND_A2]   = CFG_DATA_BITS'(pick_extreme(COEF_MIN, COEF_MAX));
      w[CFG_WET_GAIN]    = ($urandom_range(0, 1) == 1) ? GAIN_MAX : 0;
      w[CFG_SHAPE_COEFF] = ($urandom_range(0, 1) == 1) ? SHAPE_MAX : 0;
    end
    return w;
  endfunction

  // Shared tasks --------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Offer one request after a random gap, hold it until taken, then predict
  task automatic send_pair(input sample_t s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall !== 1'b0);
    pending_outputs.push_back(excite_pair(s));
  endtask

  // Drop valid, wait for every outstanding result, then let the block go quiet
  task automatic drain_and_settle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending_outputs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write every register in turn, with random bits above each field
  task automatic load_settings(input settings_t w);
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
    logic [CFG_DATA_BITS-1:0] junk;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx  = CFG_IDX_BITS'(i);
      data = w[i];
      junk = $urandom;
      case (idx)
        CFG_WET_GAIN:    data[CFG_DATA_BITS-1:GAIN_BITS]  = junk[CFG_DATA_BITS-1:GAIN_BITS];
        CFG_SHAPE_COEFF: data[CFG_DATA_BITS-1:SHAPE_BITS] = junk[CFG_DATA_BITS-1:SHAPE_BITS];
        default:         data[CFG_DATA_BITS-1:COEFF_BITS] = junk[CFG_DATA_BITS-1:COEFF_BITS];
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      store_setting(idx, data);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_outputs.size() == 0) begin
      report_mismatch($sformatf("result %h with no request outstanding", got));
    end else begin
      want = pending_outputs.pop_front();
      if (got.left_out !== want.left_out)
        report_mismatch($sformatf("left_out %h, predicted %h", got.left_out, want.left_out));
      if (got.right_out !== want.right_out)
        report_mismatch($sformatf("right_out %h, predicted %h", got.right_out, want.right_out));
    end
  endtask

  // Result side: take and check each result, stall at random or on a hold pulse
  always @(posedge clk) begin
    if (result_valid === 1'b1 && result_stall === 1'b0) begin
      check_result(result);
      rx_wait  = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      rx_armed = !no_idle && ($urandom_range(0, 1) == 1);
    end else if (rx_armed && result_valid === 1'b1) begin
      rx_armed = 1'b0;
    end
    if (hold_pulse) begin
      rx_wait  = HOLD_CYCLES;
      rx_armed = 1'b0;
    end
    if (rx_armed) begin
      result_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      result_stall <= 1'b1;
      rx_wait--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Abort when no handshake of any kind completes for too long
  always @(posedge clk) begin
    if ((sample_valid && sample_stall === 1'b0) ||
        (result_valid === 1'b1 && !result_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Tests ---------------------------------------------------------------------

  // Registers at reset value: every output equals its input
  task automatic test_reset_passthrough();
    send_pair(make_pair(S_ZERO, S_ZERO));
    send_pair(make_pair(S_MAX, S_MIN));
    send_pair(make_pair(S_MIN, S_MAX));
    send_pair(make_pair(S_NEG, S_ONE));
    send_pair(make_pair(24'h555555, 24'haaaaaa));
    send_pair(make_pair(24'haaaaaa, 24'h555555));
  endtask

  // Realistic low-pass, shaper and high-pass, fed with impulses and steps
  task automatic test_typical_exciter();
    settings_t w;
    w[CFG_FIRST_B0]    = CFG_DATA_BITS'(409490);
    w[CFG_FIRST_A1]    = CFG_DATA_BITS'(-3954460);
    w[CFG_FIRST_A2]    = CFG_DATA_BITS'(1398101);
    w[CFG_SECOND_B0]   = CFG_DATA_BITS'(2386720);
    w[CFG_SECOND_A1]   = CFG_DATA_BITS'(-3954460);
    w[CFG_SECOND_A2]   = CFG_DATA_BITS'(1398101);
    w[CFG_WET_GAIN]    = CFG_DATA_BITS'(1 << GAIN_FRAC);
    w[CFG_SHAPE_COEFF] = CFG_DATA_BITS'(49152);
    drain_and_settle();
    load_settings(w);
    send_pair(make_pair(S_MAX, S_MIN));
    send_pair(make_pair(S_ZERO, S_ZERO));
    send_pair(make_pair(S_ZERO, S_ZERO));
    send_pair(make_pair(S_MIN, S_MAX));
    send_pair(make_pair(24'h200000, 24'he00000));
    send_pair(make_pair(S_NEG, S_ONE));
    send_pair(make_pair(S_MAX, S_MAX));
  endtask

  // Every register at an extreme: unstable filters clip internally and at the output
  task automatic test_saturation();
    settings_t w;
    w[CFG_FIRST_B0]    = CFG_DATA_BITS'(COEF_MAX);
    w[CFG_FIRST_A1]    = CFG_DATA_BITS'(COEF_MIN);
    w[CFG_FIRST_A2]    = CFG_DATA_BITS'(COEF_MAX);
    w[CFG_SECOND_B0]   = CFG_DATA_BITS'(COEF_MIN);
    w[CFG_SECOND_A1]   = CFG_DATA_BITS'(COEF_MAX);
    w[CFG_SECOND_A2]   = CFG_DATA_BITS'(COEF_MIN);
    w[CFG_WET_GAIN]    = CFG_DATA_BITS'(GAIN_MAX);
    w[CFG_SHAPE_COEFF] = CFG_DATA_BITS'(SHAPE_MAX);
    drain_and_settle();
    load_settings(w);
    send_pair(make_pair(S_MAX, S_MIN));
    send_pair(make_pair(S_MAX, S_MAX));
    send_pair(make_pair(S_MIN, S_MIN));
    send_pair(make_pair(S_ZERO, S_ZERO));
    send_pair(make_pair(S_ONE, S_NEG));
    send_pair(make_pair(S_MIN, S_MAX));
  endtask

  // Hold off results for a long stretch while requests keep coming back to back
  task automatic test_backpressure();
    drain_and_settle();
    load_settings(random_settings());
    no_idle = 1'b1;
    hold_pulse <= 1'b1;
    @(posedge clk);
    hold_pulse <= 1'b0;
    for (int i = 0; i < 16; i++) send_pair(make_pair(rand_field(), rand_field()));
    no_idle = 1'b0;
    drain_and_settle();
  endtask

  // Random requests across a series of register settings
  task automatic test_random_settings();
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_and_settle();
      load_settings(random_settings());
      no_idle = (p % 3 == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) send_pair(make_pair(rand_field(), rand_field()));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    result_stall = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    hold_pulse   = 1'b0;
    errors       = 0;
    no_idle      = 1'b0;
    rx_wait      = 0;
    rx_armed     = 1'b0;
    stuck_cycles = 0;
    for (int i = 0; i < NUM_REGS; i++) coef[i] = 0;
    for (int c = 0; c < 2; c++) begin
      for (int t = 0; t < 2; t++) begin
        lp_in[c][t]  = 0;
        lp_out[c][t] = 0;
        hp_in[c][t]  = 0;
        hp_out[c][t] = 0;
      end
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_passthrough();
    test_typical_exciter();
    test_saturation();
    test_backpressure();
    test_random_settings();
    drain_and_settle();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
